[sv/rc4_pkg.sv]
// Shared constants, types and state encodings for the RC4 frame cipher.
`timescale 1ns / 1ps
package rc4_pkg;

    localparam int FRAME_BYTES   = 213;
    localparam int DISCARD_BYTES = 256;

    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 40;
    localparam int IV_W      = 32;
    localparam int RC4_KEY_W = KEY_W + IV_W;
    localparam int KEY_BYTES = RC4_KEY_W / BYTE_W;
    localparam int KIDX_W    = $clog2(KEY_BYTES);
    localparam int SBOX_AW   = 8;
    localparam int SBOX_LAST = (1 << SBOX_AW) - 1;
    localparam int IV_STEPS  = IV_W;
    localparam int IVCNT_W   = $clog2(IV_STEPS);
    localparam int CNT_W     = ($clog2(DISCARD_BYTES) > SBOX_AW) ?
                               $clog2(DISCARD_BYTES) : SBOX_AW;
    localparam int DISC_LAST = (DISCARD_BYTES == 0) ? 0 : DISCARD_BYTES - 1;

    typedef enum logic [3:0] {
        E_IDLE,
        E_INIT,
        E_K_RD_I,
        E_K_RD_J,
        E_K_WR_I,
        E_K_WR_J,
        E_G_RD_I,
        E_G_RD_J,
        E_G_WR_I,
        E_G_WR_J,
        E_G_RD_K,
        E_G_KS
    } t_eng_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_IV,
        T_KEY_CMD,
        T_KEY_WAIT,
        T_GEN_CMD,
        T_GEN_WAIT,
        T_PUSH
    } t_top_state;

    typedef struct packed {
        logic rekey;
        logic gen;
    } t_eng_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] ks;
    } t_eng_sts;

    typedef struct packed {
        logic            load;
        logic            step;
        logic [IV_W-1:0] iv;
    } t_iv_cmd;

endpackage

[sv/rc4_if.sv]
// Stream channel interfaces: input byte beat and output byte beat.
`timescale 1ns / 1ps
interface rc4_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_in;
    logic        first_of_message;
    logic [31:0] iv_in;

    modport source(output valid, output data_in, output first_of_message,
                   output iv_in, input ready);
    modport sink(input valid, input data_in, input first_of_message,
                 input iv_in, output ready);
endinterface

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source(output valid, output data_out, input ready);
    modport sink(input valid, input data_out, output ready);
endinterface

[sv/rc4_iv_lfsr.sv]
// IV register with a one-bit-per-cycle LFSR stepper (x^32+x^4+x^2+1).
`timescale 1ns / 1ps
module rc4_iv_lfsr
    import rc4_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_iv_cmd         i_cmd,
    output logic [IV_W-1:0] o_iv,
    output logic            o_done
);

    logic [IV_W-1:0]    r_iv,  n_iv;
    logic [IVCNT_W-1:0] r_cnt, n_cnt;
    logic               r_run, n_run;

    always_comb begin
        n_iv   = r_iv;
        n_cnt  = r_cnt;
        n_run  = r_run;
        o_done = 1'b0;
        if (i_cmd.load) begin
            n_iv = i_cmd.iv;
        end else if (i_cmd.step) begin
            n_run = 1'b1;
            n_cnt = '0;
        end else if (r_run) begin
            // shift in the feedback tap bit
            n_iv  = {r_iv[IV_W-2:0], r_iv[IV_W-1] ^ r_iv[3] ^ r_iv[1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == IVCNT_W'(IV_STEPS - 1)) begin
                n_run  = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= '0;
            r_cnt <= '0;
            r_run <= 1'b0;
        end else begin
            r_iv  <= n_iv;
            r_cnt <= n_cnt;
            r_run <= n_run;
        end
    end

    assign o_iv = r_iv;

endmodule

[sv/rc4_engine.sv]
// RC4 S-box memory with the key schedule and keystream sequencer.
`timescale 1ns / 1ps
module rc4_engine
    import rc4_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_eng_cmd             i_cmd,
    input  logic [RC4_KEY_W-1:0] i_key,
    output t_eng_sts             o_sts
);

    logic [BYTE_W-1:0] r_mem [0:SBOX_LAST];
    logic [BYTE_W-1:0] r_rd;

    t_eng_state        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [KIDX_W-1:0] r_kidx, n_kidx;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [BYTE_W-1:0] r_t, n_t;
    logic [BYTE_W-1:0] r_b, n_b;
    logic              r_disc, n_disc;

    logic               mem_we;
    logic [SBOX_AW-1:0] mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [SBOX_AW-1:0] mem_raddr;
    logic [BYTE_W-1:0]  key_byte;
    logic [BYTE_W-1:0]  sum_j;

    assign key_byte = i_key[BYTE_W*(KEY_BYTES - 1 - int'(r_kidx)) +: BYTE_W];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_kidx    = r_kidx;
        n_i       = r_i;
        n_j       = r_j;
        n_t       = r_t;
        n_b       = r_b;
        n_disc    = r_disc;
        mem_we    = 1'b0;
        mem_waddr = r_cnt[SBOX_AW-1:0];
        mem_wdata = r_cnt[BYTE_W-1:0];
        mem_raddr = r_cnt[SBOX_AW-1:0];
        sum_j     = r_j + r_rd;
        o_sts.done = 1'b0;
        o_sts.ks   = r_rd;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.rekey) begin
                    n_cnt   = '0;
                    n_state = E_INIT;
                end else if (i_cmd.gen) begin
                    n_disc  = 1'b0;
                    n_state = E_G_RD_I;
                end
            end
            E_INIT: begin
                mem_we = 1'b1;
                if (r_cnt == CNT_W'(SBOX_LAST)) begin
                    n_cnt   = '0;
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = E_K_RD_I;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            E_K_RD_I: begin
                n_state = E_K_RD_J;
            end
            E_K_RD_J: begin
                sum_j     = r_j + r_rd + key_byte;
                n_t       = r_rd;
                n_j       = sum_j;
                mem_raddr = sum_j;
                n_kidx    = (r_kidx == KIDX_W'(KEY_BYTES - 1)) ? '0 : r_kidx + 1'b1;
                n_state   = E_K_WR_I;
            end
            E_K_WR_I: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd;
                n_state   = E_K_WR_J;
            end
            E_K_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_t;
                if (r_cnt == CNT_W'(SBOX_LAST)) begin
                    n_cnt = '0;
                    n_i   = '0;
                    n_j   = '0;
                    if (DISCARD_BYTES == 0) begin
                        o_sts.done = 1'b1;
                        n_state    = E_IDLE;
                    end else begin
                        n_disc  = 1'b1;
                        n_state = E_G_RD_I;
                    end
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = E_K_RD_I;
                end
            end
            E_G_RD_I: begin
                n_i       = r_i + 1'b1;
                mem_raddr = n_i;
                n_state   = E_G_RD_J;
            end
            E_G_RD_J: begin
                n_t       = r_rd;
                n_j       = sum_j;
                mem_raddr = sum_j;
                n_state   = E_G_WR_I;
            end
            E_G_WR_I: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_rd;
                n_b       = r_rd;
                n_state   = E_G_WR_J;
            end
            E_G_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_t;
                if (!r_disc) begin
                    n_state = E_G_RD_K;
                end else if (r_cnt == CNT_W'(DISC_LAST)) begin
                    n_cnt      = '0;
                    o_sts.done = 1'b1;
                    n_state    = E_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = E_G_RD_I;
                end
            end
            E_G_RD_K: begin
                // read after both swap writes have landed
                mem_raddr = r_t + r_b;
                n_state   = E_G_KS;
            end
            E_G_KS: begin
                o_sts.done = 1'b1;
                n_state    = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
        o_sts.busy = (r_state != E_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_cnt   <= '0;
            r_kidx  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_disc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kidx  <= n_kidx;
            r_i     <= n_i;
            r_j     <= n_j;
            r_disc  <= n_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_b <= n_b;
    end

endmodule

[sv/rc4_iv_frame_stream_cipher_top.sv]
// Top level of the RC4 frame stream cipher: handshakes, framing and output register.
`timescale 1ns / 1ps
// Each input beat yields one output beat, data_in XOR the next RC4 keystream byte, so
// the same block encrypts and decrypts. The RC4 key is the 40-bit session key followed
// by the current 32-bit IV, most significant bytes first. A beat with first_of_message
// set loads iv_in and rekeys; after every 213 bytes of a frame the IV is advanced 32
// steps through x^32+x^4+x^2+1 and the block rekeys. All work goes through one 256-entry
// S-box memory with one read and one write port: a rekey fills the S-box, runs the key
// schedule and discards 256 keystream bytes, and a data byte is XORed with one keystream
// byte and placed in the output register. The input is ready only while the block is
// idle; a finished byte waits in the output register while the next beat is accepted.
// A session_key write takes effect at the next rekey. Bytes sent after reset before any
// first_of_message beat read an S-box that was never written and are undefined.
module rc4_iv_frame_stream_cipher_top
    import rc4_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_wdata,
    rc4_in_if.sink           i_in,
    rc4_out_if.source        o_out
);

    t_top_state        r_state, n_state;
    logic [KEY_W-1:0]  r_key;
    logic [BYTE_W-1:0] r_fpos, n_fpos;
    logic [BYTE_W-1:0] r_data, n_data;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic              r_out_valid, n_out_valid;

    t_eng_cmd        eng_cmd;
    t_eng_sts        eng_sts;
    t_iv_cmd         iv_cmd;
    logic [IV_W-1:0] iv;
    logic            iv_done;
    logic            in_fire;

    rc4_iv_lfsr u_iv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (iv_cmd),
        .o_iv    (iv),
        .o_done  (iv_done)
    );

    rc4_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .i_key   ({r_key, iv}),
        .o_sts   (eng_sts)
    );

    assign i_in.ready     = (r_state == T_IDLE);
    assign in_fire        = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_fpos      = r_fpos;
        n_data      = r_data;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        eng_cmd     = '0;
        iv_cmd      = '0;
        iv_cmd.iv   = i_in.iv_in;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            T_IDLE: begin
                if (in_fire) begin
                    n_data = i_in.data_in;
                    if (i_in.first_of_message) begin
                        iv_cmd.load = 1'b1;
                        n_fpos      = '0;
                        n_state     = T_KEY_CMD;
                    end else if (r_fpos >= BYTE_W'(FRAME_BYTES)) begin
                        iv_cmd.step = 1'b1;
                        n_fpos      = '0;
                        n_state     = T_IV;
                    end else begin
                        n_state = T_GEN_CMD;
                    end
                end
            end
            T_IV: begin
                if (iv_done) begin
                    n_state = T_KEY_CMD;
                end
            end
            T_KEY_CMD: begin
                eng_cmd.rekey = 1'b1;
                n_state       = T_KEY_WAIT;
            end
            T_KEY_WAIT: begin
                if (eng_sts.done) begin
                    n_state = T_GEN_CMD;
                end
            end
            T_GEN_CMD: begin
                eng_cmd.gen = 1'b1;
                n_state     = T_GEN_WAIT;
            end
            T_GEN_WAIT: begin
                if (eng_sts.done) begin
                    n_data  = r_data ^ eng_sts.ks;
                    n_fpos  = r_fpos + 1'b1;
                    n_state = T_PUSH;
                end
            end
            T_PUSH: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_data  = r_data;
                    n_out_valid = 1'b1;
                    n_state     = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_key       <= '0;
            r_fpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fpos      <= n_fpos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_out_data <= n_out_data;
    end

    a_ready_engine_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !eng_sts.busy)
        else $error("input ready while the S-box engine is busy");

    a_fpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fpos <= BYTE_W'(FRAME_BYTES))
        else $error("frame position ran past the frame length");

    a_iv_done_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iv_done |-> (r_state == T_IV))
        else $error("IV stepper finished outside the IV step phase");

    a_gen_to_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_GEN_WAIT && eng_sts.done) |=> (r_state == T_PUSH))
        else $error("keystream byte finished without moving to the output stage");

endmodule

[sim/tb_rc4_iv_frame_stream_cipher_top.sv]
// Self-checking testbench for the RC4 IV frame stream cipher top level.
`timescale 1ns / 1ps
module tb_rc4_iv_frame_stream_cipher_top
    import rc4_pkg::*;
();

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

    bit   i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [KEY_W-1:0] i_cfg_wdata;

    rc4_in_if  in_if();
    rc4_out_if out_if();

    rc4_iv_frame_stream_cipher_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Cipher state mirror
    bit [7:0]         ks_sbox [256];
    bit [7:0]         ks_i;
    bit [7:0]         ks_j;
    bit [IV_W-1:0]    frame_iv;
    int unsigned      frame_used;
    bit [KEY_W-1:0]   key_shadow;

    bit [7:0]         expected_bytes [$];
    int unsigned      error_count;
    bit               src_idle_en;
    bit               sink_idle_en;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit [7:0] keystream_next();
        bit [7:0] a;
        bit [7:0] b;
        bit [7:0] k;
        ks_i = ks_i + 8'd1;
        a = ks_sbox[ks_i];
        ks_j = ks_j + a;
        b = ks_sbox[ks_j];
        ks_sbox[ks_i] = b;
        ks_sbox[ks_j] = a;
        k = a + b;
        return ks_sbox[k];
    endfunction

    function automatic void schedule_key();
        bit [7:0] key_bytes [KEY_BYTES];
        bit [7:0] j;
        bit [7:0] t;
        for (int n = 0; n < 5; n++) begin
            key_bytes[n] = key_shadow[KEY_W-1-8*n -: 8];
        end
        for (int n = 0; n < 4; n++) begin
            key_bytes[5+n] = frame_iv[IV_W-1-8*n -: 8];
        end
        for (int n = 0; n < 256; n++) begin
            ks_sbox[n] = 8'(n);
        end
        j = 8'd0;
        for (int n = 0; n < 256; n++) begin
            t = ks_sbox[n];
            j = j + t + key_bytes[n % KEY_BYTES];
            ks_sbox[n] = ks_sbox[j];
            ks_sbox[j] = t;
        end
        ks_i = 8'd0;
        ks_j = 8'd0;
        repeat (DISCARD_BYTES) void'(keystream_next());
        frame_used = 0;
    endfunction

    function automatic void advance_iv();
        bit fb;
        for (int n = 0; n < IV_STEPS; n++) begin
            fb = frame_iv[31] ^ frame_iv[3] ^ frame_iv[1];
            frame_iv = {frame_iv[30:0], fb};
        end
    endfunction

    function automatic bit [7:0] cipher_byte(input bit [7:0] data, input bit fom,
                                             input bit [IV_W-1:0] iv);
        if (fom) begin
            frame_iv = iv;
            schedule_key();
        end else if (frame_used >= FRAME_BYTES) begin
            // frame exhausted: step the IV and rekey before this byte
            advance_iv();
            schedule_key();
        end
        frame_used++;
        return data ^ keystream_next();
    endfunction

    function automatic bit [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return KEY_ONES;
            default: return {8'($urandom_range(0, 255)), 32'($urandom())};
        endcase
    endfunction

    task automatic send_byte(input bit [7:0] data, input bit fom, input bit [IV_W-1:0] iv);
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.data_in          <= data;
        in_if.first_of_message <= fom;
        in_if.iv_in            <= iv;
        do @(posedge i_clk); while (!in_if.ready);
        expected_bytes = {expected_bytes, cipher_byte(data, fom, iv)};
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Write the key only once the block has drained every byte
    task automatic write_key(input bit [KEY_W-1:0] key);
        idle_input();
        wait (expected_bytes.size() == 0);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= key;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        key_shadow = key;
    endtask

    // Reset key of zero, extreme data values and an all-zero IV
    task automatic test_reset_key();
        send_byte(8'h00, 1'b1, 32'h0000_0000);
        send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h55, 1'b0, 32'h5555_5555);
        send_byte(8'hAA, 1'b0, 32'hAAAA_AAAA);
    endtask

    task automatic test_key_all_ones();
        write_key(KEY_ONES);
        send_byte(8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0, 32'h0000_0000);
        send_byte(8'h81, 1'b0, 32'h8000_0001);
    endtask

    // Restart inside a frame, including a restart with the same IV
    task automatic test_restart_mid_frame();
        bit [IV_W-1:0] iv;
        write_key(40'h01_2345_6789);
        iv = 32'($urandom());
        send_byte(8'h12, 1'b1, iv);
        send_byte(8'h34, 1'b0, 32'($urandom()));
        send_byte(8'h56, 1'b1, 32'hDEAD_BEEF);
        send_byte(8'h78, 1'b0, 32'($urandom()));
        send_byte(8'h12, 1'b1, iv);
        send_byte(8'h34, 1'b0, 32'($urandom()));
    endtask

    // A new key waits for the next rekey
    task automatic test_key_change_pending();
        send_byte(8'h9A, 1'b1, 32'h0123_4567);
        write_key(40'hA5_5A5A_A5A5);
        send_byte(8'hBC, 1'b0, 32'($urandom()));
        send_byte(8'hDE, 1'b0, 32'($urandom()));
        send_byte(8'hF0, 1'b1, 32'h0123_4567);
        send_byte(8'h0F, 1'b0, 32'($urandom()));
    endtask

    // Fill a whole frame, change the key, then cross into the next frame
    task automatic test_frame_rollover();
        send_byte(8'($urandom_range(0, 255)), 1'b1, 32'($urandom()));
        for (int n = 1; n < FRAME_BYTES; n++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 32'($urandom()));
        end
        write_key(rand_key());
        for (int n = 0; n < 20; n++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 32'($urandom()));
        end
    endtask

    task automatic test_random_messages(input int unsigned target);
        int unsigned sent;
        int unsigned phase_sent;
        int unsigned len;
        bit          cont;
        bit [IV_W-1:0] iv;
        sent = 0;
        phase_sent = 0;
        while (sent < target) begin
            if (phase_sent >= 90) begin
                write_key(rand_key());
                phase_sent = 0;
            end
            if (target - sent < 90) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 440)
                                               : $urandom_range(1, 24);
            if (len > target - sent) begin
                len = target - sent;
            end
            cont = ($urandom_range(0, 7) == 0);
            iv   = 32'($urandom());
            for (int n = 0; n < len; n++) begin
                send_byte(8'($urandom_range(0, 255)), (n == 0) && !cont,
                          (n == 0) ? iv : 32'($urandom()));
            end
            sent       += len;
            phase_sent += len;
        end
    endtask

    // Output sink with random stall bursts
    initial begin
        int unsigned hold;
        hold = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                hold = $urandom_range(0, 8);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        bit [7:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                $error("data_out: unexpected beat, expected none, actual %02h",
                       out_if.data_out);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_if.data_out !== want) begin
                    $error("data_out: expected %02h, actual %02h", want, out_if.data_out);
                    error_count++;
                end
            end
        end
    end

    // End the run if no beat moves on either side for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        in_if.valid            = 1'b0;
        in_if.data_in          = '0;
        in_if.first_of_message = 1'b0;
        in_if.iv_in            = '0;
        i_cfg_we               = 1'b0;
        i_cfg_wdata            = '0;
        i_rst_n                = 1'b0;
        error_count            = 0;
        src_idle_en            = 1'b1;
        sink_idle_en           = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_key_all_ones();
        test_restart_mid_frame();
        test_key_change_pending();
        test_frame_rollover();
        test_random_messages(270);

        idle_input();
        wait (expected_bytes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
